/* hw/rtl/f12te_pkg.sv */
`timescale 1ns / 1ps

package f12te_pkg;

    localparam int MAX_ENTRIES  = 4096;
    localparam int SECTOR_BYTES = 512;
    localparam int TABLE_BYTES  = (MAX_ENTRIES * 3 + 1) / 2;

    localparam int OP_W        = 3;
    localparam int BYTE_ADDR_W = 13;
    localparam int BYTE_W      = 8;
    localparam int ENTRY_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int FBYTES_W    = 22;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [COUNT_W-1:0]  ENTRIES_RESET  = COUNT_W'(2849);
    localparam logic [FBYTES_W-1:0] FREE_BYTES_MAX = '1;

    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_BYTE  = 3'd0,
        OP_READ_BYTE   = 3'd1,
        OP_READ_ENTRY  = 3'd2,
        OP_WRITE_ENTRY = 3'd3,
        OP_FIND_FREE   = 3'd4,
        OP_COUNT_FREE  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BYTE_RD,
        ST_ENT_RD0,
        ST_ENT_RD1,
        ST_ENT_WR,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [ENTRY_W-1:0]  read_data;
        logic                found;
        logic [ENTRY_W-1:0]  free_index;
        logic [COUNT_W-1:0]  free_count;
        logic [FBYTES_W-1:0] free_bytes;
    } t_result;

endpackage

/* hw/rtl/f12te_in_if.sv */
`timescale 1ns / 1ps

interface f12te_in_if;
    import f12te_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [BYTE_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]      byte_value;
    logic [ENTRY_W-1:0]     entry_index;
    logic [ENTRY_W-1:0]     entry_value;

    modport source (
        output valid, op, byte_address, byte_value, entry_index, entry_value,
        input  ready
    );

    modport sink (
        input  valid, op, byte_address, byte_value, entry_index, entry_value,
        output ready
    );
endinterface

/* hw/rtl/f12te_out_if.sv */
`timescale 1ns / 1ps

interface f12te_out_if;
    import f12te_pkg::*;

    logic                valid;
    logic                ready;
    logic [ENTRY_W-1:0]  read_data;
    logic                found;
    logic [ENTRY_W-1:0]  free_index;
    logic [COUNT_W-1:0]  free_count;
    logic [FBYTES_W-1:0] free_bytes;

    modport source (
        output valid, read_data, found, free_index, free_count, free_bytes,
        input  ready
    );

    modport sink (
        input  valid, read_data, found, free_index, free_count, free_bytes,
        output ready
    );
endinterface

/* hw/rtl/fat12_table_engine.sv */
`timescale 1ns / 1ps

// FAT12 allocation table engine. The table lives in one byte-wide memory of
// 6144 bytes with one read and one write port, and every operation is paced by
// that single read port. After reset the block clears the memory to zero and
// takes no item in that time, though configuration writes are accepted. A raw
// byte write finishes on acceptance, a raw byte read goes through ST_BYTE_RD,
// an entry write stores one byte on acceptance and the shared byte in ST_ENT_WR,
// and an entry read gathers its bytes in ST_ENT_RD0 and ST_ENT_RD1. Find-free
// and count-free stream the table one byte per cycle, and finish on acceptance
// when no entries are in use. Each item returns one result through an output
// register, and a new item may be accepted while the result waits to be taken.
module fat12_table_engine (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    f12te_in_if.sink                 i_item,
    f12te_out_if.source              o_result,
    input  logic                     i_psel,
    input  logic                     i_penable,
    input  logic                     i_pwrite,
    input  logic [f12te_pkg::PADDR_W-1:0] i_paddr,
    input  logic [f12te_pkg::PDATA_W-1:0] i_pwdata,
    output logic [f12te_pkg::PDATA_W-1:0] o_prdata,
    output logic                     o_pready
);
    import f12te_pkg::*;

    localparam int PROD_W = COUNT_W + 13;

    logic [BYTE_W-1:0] mem [TABLE_BYTES];

    t_state r_state, n_state;

    logic [BYTE_ADDR_W-1:0] r_clr_addr;
    logic [COUNT_W-1:0]     r_cfg_entries;
    logic                   r_scan_find;
    logic                   r_odd;
    logic [BYTE_ADDR_W-1:0] r_addr;
    logic [ENTRY_W-1:0]     r_ent_val;
    logic [BYTE_W-1:0]      r_lo_byte;
    logic [BYTE_ADDR_W-1:0] r_raddr;
    logic [1:0]             r_phase;
    logic [BYTE_W-1:0]      r_prev;
    logic [ENTRY_W-1:0]     r_eidx;
    logic [ENTRY_W-1:0]     r_nlast;
    logic [COUNT_W-1:0]     r_cnt;
    logic [BYTE_W-1:0]      r_rdata;
    t_result                r_res;
    t_result                r_out;
    logic                   r_out_valid;

    logic                   w_accept;
    logic                   w_slot_free;
    logic                   w_in_ready;
    logic                   w_re;
    logic [BYTE_ADDR_W-1:0] w_raddr;
    logic                   w_we;
    logic [BYTE_ADDR_W-1:0] w_waddr;
    logic [BYTE_W-1:0]      w_wdata;
    logic                   w_finish;
    t_result                w_res;
    logic                   w_cfg_write;
    logic [BYTE_ADDR_W-1:0] w_ent_b;
    logic                   w_ent_ok;
    logic                   w_byte_ok;
    logic [ENTRY_W-1:0]     w_scan_entry;
    logic                   w_ent_done;
    logic                   w_zero;
    logic                   w_last;
    logic                   w_stop;
    logic [COUNT_W-1:0]     w_cnt_next;
    logic [PROD_W-1:0]      w_prod;
    logic [ENTRY_W-1:0]     w_nlast;

    assign w_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_item.valid && w_in_ready;
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign i_item.ready = w_in_ready;

    assign w_ent_b   = BYTE_ADDR_W'(i_item.entry_index)
                     + BYTE_ADDR_W'(i_item.entry_index >> 1);
    assign w_ent_ok  = 32'(i_item.entry_index) < MAX_ENTRIES;
    assign w_byte_ok = 32'(i_item.byte_address) < TABLE_BYTES;
    assign w_nlast   = (32'(r_cfg_entries) > MAX_ENTRIES) ? ENTRY_W'(MAX_ENTRIES - 1)
                     : ENTRY_W'(r_cfg_entries - COUNT_W'(1));

    assign w_scan_entry = (r_phase == 2'd1) ? {r_rdata[3:0], r_prev}
                                            : {r_rdata, r_prev[7:4]};
    assign w_ent_done = (r_state == ST_SCAN) && (r_phase != 2'd0);
    assign w_zero     = (w_scan_entry == '0);
    assign w_last     = (r_eidx == r_nlast);
    assign w_stop     = w_ent_done && ((r_scan_find && w_zero) || w_last);
    assign w_cnt_next = r_cnt + COUNT_W'(w_zero);
    assign w_prod     = PROD_W'(w_cnt_next) * PROD_W'(SECTOR_BYTES);

    assign w_cfg_write = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr[2] == REG_ENTRIES_IN_USE);
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_ENTRIES_IN_USE) ? PDATA_W'(r_cfg_entries) : '0;

    always_comb begin
        w_re       = 1'b0;
        w_raddr    = '0;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_finish   = 1'b0;
        w_res      = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.op)
                        OP_WRITE_BYTE: begin
                            w_we     = w_byte_ok;
                            w_waddr  = i_item.byte_address;
                            w_wdata  = i_item.byte_value;
                            w_finish = 1'b1;
                        end
                        OP_READ_BYTE: begin
                            w_re     = w_byte_ok;
                            w_raddr  = i_item.byte_address;
                            w_finish = !w_byte_ok;
                        end
                        OP_READ_ENTRY: begin
                            w_re     = w_ent_ok;
                            w_raddr  = w_ent_b;
                            w_finish = !w_ent_ok;
                        end
                        OP_WRITE_ENTRY: begin
                            w_re     = w_ent_ok;
                            w_we     = w_ent_ok;
                            w_finish = !w_ent_ok;
                            if (i_item.entry_index[0]) begin
                                w_raddr = w_ent_b;
                                w_waddr = w_ent_b + BYTE_ADDR_W'(1);
                                w_wdata = i_item.entry_value[11:4];
                            end else begin
                                w_raddr = w_ent_b + BYTE_ADDR_W'(1);
                                w_waddr = w_ent_b;
                                w_wdata = i_item.entry_value[7:0];
                            end
                        end
                        OP_FIND_FREE, OP_COUNT_FREE: begin
                            w_re     = (r_cfg_entries != '0);
                            w_finish = (r_cfg_entries == '0);
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_BYTE_RD: begin
                w_finish            = 1'b1;
                w_res.read_data     = ENTRY_W'(r_rdata);
            end
            ST_ENT_RD0: begin
                w_re    = 1'b1;
                w_raddr = r_addr + BYTE_ADDR_W'(r_odd);
            end
            ST_ENT_RD1: begin
                w_finish        = 1'b1;
                w_res.read_data = r_odd ? {r_rdata, r_lo_byte[7:4]}
                                        : {r_rdata[3:0], r_lo_byte};
            end
            ST_ENT_WR: begin
                w_we     = 1'b1;
                w_waddr  = r_addr;
                w_wdata  = r_odd ? {r_ent_val[3:0], r_rdata[3:0]}
                                 : {r_rdata[7:4], r_ent_val[11:8]};
                w_finish = 1'b1;
            end
            ST_SCAN: begin
                w_re    = (32'(r_raddr) < TABLE_BYTES);
                w_raddr = r_raddr;
                if (w_stop) begin
                    w_finish = 1'b1;
                    if (r_scan_find) begin
                        w_res.found      = w_zero;
                        w_res.free_index = w_zero ? r_eidx : '0;
                    end else begin
                        w_res.free_count = w_cnt_next;
                        w_res.free_bytes = (w_prod > PROD_W'(FREE_BYTES_MAX))
                                         ? FREE_BYTES_MAX : FBYTES_W'(w_prod);
                    end
                end
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (32'(r_clr_addr) == TABLE_BYTES - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_finish) begin
                        n_state = w_slot_free ? ST_IDLE : ST_OUT;
                    end else begin
                        unique case (i_item.op)
                            OP_READ_BYTE:   n_state = ST_BYTE_RD;
                            OP_READ_ENTRY:  n_state = ST_ENT_RD0;
                            OP_WRITE_ENTRY: n_state = ST_ENT_WR;
                            default:        n_state = ST_SCAN;
                        endcase
                    end
                end
            end
            ST_ENT_RD0: begin
                n_state = ST_ENT_RD1;
            end
            ST_BYTE_RD, ST_ENT_RD1, ST_ENT_WR, ST_SCAN: begin
                if (w_finish) begin
                    n_state = w_slot_free ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT: begin
                if (o_result.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_cfg_entries <= ENTRIES_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + BYTE_ADDR_W'(1);
            end
            if (w_cfg_write) begin
                r_cfg_entries <= i_pwdata[COUNT_W-1:0];
            end
            if (w_finish && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_OUT && o_result.ready) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish && w_slot_free) begin
            r_out <= w_res;
        end else if (r_state == ST_OUT && o_result.ready) begin
            r_out <= r_res;
        end
        if (w_finish) begin
            r_res <= w_res;
        end
        if (w_accept) begin
            r_scan_find <= (i_item.op == OP_FIND_FREE);
            r_odd       <= i_item.entry_index[0];
            r_ent_val   <= i_item.entry_value;
            r_addr      <= i_item.entry_index[0] ? w_ent_b : w_ent_b + BYTE_ADDR_W'(1);
            r_nlast     <= w_nlast;
            r_eidx      <= '0;
            r_cnt       <= '0;
            r_phase     <= 2'd0;
            r_raddr     <= BYTE_ADDR_W'(1);
        end
        if (r_state == ST_ENT_RD0) begin
            r_lo_byte <= r_rdata;
        end
        if (r_state == ST_SCAN) begin
            r_prev  <= r_rdata;
            r_raddr <= r_raddr + BYTE_ADDR_W'(1);
            r_phase <= (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            if (w_ent_done) begin
                r_eidx <= r_eidx + ENTRY_W'(1);
                r_cnt  <= w_cnt_next;
            end
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.read_data  = r_out.read_data;
    assign o_result.found      = r_out.found;
    assign o_result.free_index = r_out.free_index;
    assign o_result.free_count = r_out.free_count;
    assign o_result.free_bytes = r_out.free_bytes;

endmodule

/* tb/sv/fat12_table_engine_tb.sv */
`timescale 1ns / 1ps

module fat12_table_engine_tb;
    import f12te_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam int unsigned REG_SPARE = 1;
    localparam int unsigned WATCHDOG_LIMIT = 50000;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OP_W-1:0]        op;
        logic [BYTE_ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0]      byte_value;
        logic [ENTRY_W-1:0]     entry_index;
        logic [ENTRY_W-1:0]     entry_value;
    } t_table_op;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [PADDR_W-1:0] i_paddr;
    logic [PDATA_W-1:0] i_pwdata;
    logic [PDATA_W-1:0] o_prdata;
    logic o_pready;

    f12te_in_if  item_if ();
    f12te_out_if result_if ();

    fat12_table_engine u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .o_result  (result_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #6 i_clk = ~i_clk;

    logic [BYTE_W-1:0] fat_image [TABLE_BYTES];
    logic [COUNT_W-1:0] scan_setting;
    t_result table_results [$];

    bit sender_gaps;
    bit receiver_stalls;
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned settings_used;
    int unsigned finds_hit;
    int unsigned finds_missed;

    function automatic logic [ENTRY_W-1:0] entry_of(input int unsigned e);
        int unsigned b;
        b = (3 * e) / 2;
        if (e >= MAX_ENTRIES) return '0;
        if (e % 2 == 0) return {fat_image[b + 1][3:0], fat_image[b]};
        return {fat_image[b + 1], fat_image[b][7:4]};
    endfunction

    function automatic void store_entry(input int unsigned e, input logic [ENTRY_W-1:0] v);
        int unsigned b;
        b = (3 * e) / 2;
        if (e >= MAX_ENTRIES) return;
        if (e % 2 == 0) begin
            fat_image[b] = v[7:0];
            fat_image[b + 1][3:0] = v[11:8];
        end else begin
            fat_image[b][7:4] = v[3:0];
            fat_image[b + 1] = v[11:4];
        end
    endfunction

    function automatic t_result apply_fat_op(input t_table_op it);
        t_result r;
        int unsigned limit;
        int unsigned tally;
        int unsigned i;
        longint unsigned product;
        r = '0;
        tally = 0;
        limit = (scan_setting > MAX_ENTRIES) ? MAX_ENTRIES : scan_setting;
        case (it.op)
            OP_WRITE_BYTE: begin
                if (it.byte_address < TABLE_BYTES) fat_image[it.byte_address] = it.byte_value;
            end
            OP_READ_BYTE: begin
                if (it.byte_address < TABLE_BYTES) begin
                    r.read_data = ENTRY_W'(fat_image[it.byte_address]);
                end
            end
            OP_READ_ENTRY: begin
                r.read_data = entry_of(it.entry_index);
            end
            OP_WRITE_ENTRY: begin
                store_entry(it.entry_index, it.entry_value);
            end
            OP_FIND_FREE: begin
                for (i = 0; i < limit && !r.found; i++) begin
                    if (entry_of(i) == '0) begin
                        r.found = 1'b1;
                        r.free_index = ENTRY_W'(i);
                    end
                end
            end
            OP_COUNT_FREE: begin
                for (i = 0; i < limit; i++) begin
                    if (entry_of(i) == '0) tally++;
                end
                r.free_count = COUNT_W'(tally);
                product = longint'(tally) * SECTOR_BYTES;
                r.free_bytes = (product > FREE_BYTES_MAX) ? FREE_BYTES_MAX : FBYTES_W'(product);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_table_op table_op(input logic [OP_W-1:0] op, input int unsigned addr,
                                           input int unsigned bval, input int unsigned idx,
                                           input int unsigned value);
        t_table_op it;
        it.op = op;
        it.byte_address = BYTE_ADDR_W'(addr);
        it.byte_value = BYTE_W'(bval);
        it.entry_index = ENTRY_W'(idx);
        it.entry_value = ENTRY_W'(value);
        return it;
    endfunction

    function automatic t_table_op random_table_op(input int unsigned span);
        t_table_op it;
        int unsigned pick;
        int unsigned near_entry;
        int unsigned near_byte;
        it.op = OP_W'($urandom_range(0, 7));
        it.byte_address = BYTE_ADDR_W'($urandom);
        it.byte_value = BYTE_W'($urandom);
        it.entry_index = ENTRY_W'($urandom);
        it.entry_value = ENTRY_W'($urandom);
        near_entry = $urandom_range(0, span + 1);
        if (near_entry > MAX_ENTRIES - 1) near_entry = MAX_ENTRIES - 1;
        near_byte = $urandom_range(0, (3 * span) / 2 + 2);
        if (near_byte > 8191) near_byte = 8191;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            it.op = OP_WRITE_ENTRY;
            it.entry_index = ENTRY_W'(near_entry);
            if ($urandom_range(0, 3) == 0) it.entry_value = '0;
        end else if (pick < 40) begin
            it.op = OP_READ_ENTRY;
            if ($urandom_range(0, 4) != 0) it.entry_index = ENTRY_W'(near_entry);
        end else if (pick < 52) begin
            it.op = OP_WRITE_BYTE;
            if ($urandom_range(0, 4) != 0) it.byte_address = BYTE_ADDR_W'(near_byte);
        end else if (pick < 64) begin
            it.op = OP_READ_BYTE;
            if ($urandom_range(0, 4) != 0) it.byte_address = BYTE_ADDR_W'(near_byte);
        end else if (pick < 76) begin
            it.op = OP_FIND_FREE;
        end else if (pick < 86) begin
            it.op = OP_COUNT_FREE;
        end else if (pick < 92) begin
            it.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        end else begin
            it.op = OP_WRITE_ENTRY;
        end
        return it;
    endfunction

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("Mismatch: %s", what);
    endtask

    task automatic push_table_op(input t_table_op it);
        t_result want;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.op <= it.op;
        item_if.byte_address <= it.byte_address;
        item_if.byte_value <= it.byte_value;
        item_if.entry_index <= it.entry_index;
        item_if.entry_value <= it.entry_value;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        want = apply_fat_op(it);
        table_results.push_back(want);
        items_sent++;
        if (it.op == OP_FIND_FREE) begin
            if (want.found) finds_hit++;
            else finds_missed++;
        end
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (table_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input int unsigned reg_index, input logic [PDATA_W-1:0] data);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= PADDR_W'(4 * reg_index);
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        if (reg_index == REG_ENTRIES_IN_USE) scan_setting = data[COUNT_W-1:0];
    endtask

    task automatic check_scan_setting();
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= PADDR_W'(4 * REG_ENTRIES_IN_USE);
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata !== PDATA_W'(scan_setting)) begin
            note_mismatch($sformatf("register read expected %0d, got %0d",
                                    scan_setting, o_prdata));
        end
        i_psel <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic set_scan_entries(input logic [COUNT_W-1:0] entries);
        drain_results();
        apb_write(REG_ENTRIES_IN_USE, ($urandom & ~PDATA_W'(32'h1FFF)) | PDATA_W'(entries));
        settings_used++;
        check_scan_setting();
    endtask

    task automatic test_after_reset();
        check_scan_setting();
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
        push_table_op(table_op(OP_FIND_FREE, 0, 0, 0, 0));
    endtask

    task automatic test_scan_limits();
        set_scan_entries(COUNT_W'(MAX_ENTRIES));
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
        set_scan_entries('1);
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
        push_table_op(table_op(OP_FIND_FREE, 0, 0, 0, 0));
        set_scan_entries('0);
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
        push_table_op(table_op(OP_FIND_FREE, 0, 0, 0, 0));
        drain_results();
        apb_write(REG_SPARE, PDATA_W'(MAX_ENTRIES));
        check_scan_setting();
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
    endtask

    task automatic test_entry_packing();
        set_scan_entries(COUNT_W'(4));
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, 1, 12'hFFF));
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, 0, 12'h123));
        push_table_op(table_op(OP_READ_ENTRY, 0, 0, 1, 0));
        push_table_op(table_op(OP_READ_BYTE, 1, 0, 0, 0));
        push_table_op(table_op(OP_READ_ENTRY, 0, 0, 0, 0));
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, 2, 12'h001));
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, 3, 12'h800));
        push_table_op(table_op(OP_FIND_FREE, 0, 0, 0, 0));
        push_table_op(table_op(OP_COUNT_FREE, 0, 0, 0, 0));
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, 1, 12'h000));
        push_table_op(table_op(OP_FIND_FREE, 0, 0, 0, 0));
    endtask

    task automatic test_out_of_range();
        push_table_op(table_op(OP_WRITE_ENTRY, 0, 0, MAX_ENTRIES - 1, 12'hFFF));
        push_table_op(table_op(OP_READ_ENTRY, 0, 0, MAX_ENTRIES - 1, 0));
        push_table_op(table_op(OP_READ_BYTE, TABLE_BYTES - 1, 0, 0, 0));
        push_table_op(table_op(OP_WRITE_BYTE, 8191, 8'hFF, 0, 0));
        push_table_op(table_op(OP_READ_BYTE, 8191, 0, 0, 0));
        push_table_op(table_op(OP_READ_BYTE, TABLE_BYTES, 0, 0, 0));
    endtask

    task automatic test_spare_ops();
        push_table_op(table_op(OP_SPARE_A, 5, 8'hFF, 3, 12'hFFF));
        push_table_op(table_op(OP_SPARE_B, 8191, 8'hFF, 4095, 12'hFFF));
    endtask

    task automatic run_block(input int unsigned count);
        int unsigned span;
        span = (scan_setting > MAX_ENTRIES) ? MAX_ENTRIES : scan_setting;
        if (span < 8) span = 8;
        repeat (count) push_table_op(random_table_op(span));
    endtask

    task automatic test_random_traffic();
        int unsigned blk;
        int unsigned mode;
        for (blk = 0; blk < 14; blk++) begin
            case (blk % 7)
                3: set_scan_entries(COUNT_W'($urandom_range(1000, 8191)));
                6: set_scan_entries(COUNT_W'($urandom_range(0, 3)));
                default: set_scan_entries(COUNT_W'($urandom_range(1, 40)));
            endcase
            mode = $urandom_range(0, 3);
            sender_gaps = mode[0];
            receiver_stalls = mode[1];
            run_block(100);
        end
    endtask

    task automatic test_unpaced_traffic();
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        set_scan_entries(COUNT_W'($urandom_range(1, 40)));
        run_block(125);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (result_if.valid && result_if.ready) begin
            got.read_data = result_if.read_data;
            got.found = result_if.found;
            got.free_index = result_if.free_index;
            got.free_count = result_if.free_count;
            got.free_bytes = result_if.free_bytes;
            results_checked++;
            if (table_results.size() == 0) begin
                note_mismatch($sformatf("result with nothing outstanding: %p", got));
            end else begin
                want = table_results.pop_front();
                if (got.read_data !== want.read_data || got.found !== want.found ||
                    got.free_index !== want.free_index ||
                    got.free_count !== want.free_count ||
                    got.free_bytes !== want.free_bytes) begin
                    note_mismatch($sformatf(
                        "expected rd=%h found=%b idx=%0d cnt=%0d bytes=%0d, got rd=%h found=%b idx=%0d cnt=%0d bytes=%0d",
                        want.read_data, want.found, want.free_index, want.free_count,
                        want.free_bytes, got.read_data, got.found, got.free_index,
                        got.free_count, got.free_bytes));
                end
            end
        end
    end

    initial begin : result_pacing
        int unsigned hold;
        hold = 0;
        result_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold == 0 && receiver_stalls && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 13);
            end
            if (hold != 0) begin
                result_if.ready <= 1'b0;
                hold--;
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Timed out after %0d cycles without a transfer.", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_sequence
        i_rst_n <= 1'b0;
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        i_paddr <= '0;
        i_pwdata <= '0;
        item_if.valid <= 1'b0;
        item_if.op <= '0;
        item_if.byte_address <= '0;
        item_if.byte_value <= '0;
        item_if.entry_index <= '0;
        item_if.entry_value <= '0;
        for (int b = 0; b < TABLE_BYTES; b++) fat_image[b] = '0;
        scan_setting = ENTRIES_RESET;
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        mismatch_count = 0;
        items_sent = 0;
        results_checked = 0;
        settings_used = 0;
        finds_hit = 0;
        finds_missed = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_scan_limits();
        test_entry_packing();
        test_out_of_range();
        test_spare_ops();
        test_random_traffic();
        test_unpaced_traffic();

        drain_results();
        repeat (32) @(posedge i_clk);
        if (table_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", table_results.size()));
        end
        $display("Covered %0d table operations and %0d checked results over %0d scan lengths.",
                 items_sent, results_checked, settings_used);
        $display("Find-free located an entry %0d times and came up empty %0d times; %0d mismatches.",
                 finds_hit, finds_missed, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/f12te_pkg.sv
hw/rtl/f12te_in_if.sv
hw/rtl/f12te_out_if.sv
hw/rtl/fat12_table_engine.sv
tb/sv/fat12_table_engine_tb.sv
